/* src/stt_pkg.sv */
// Shared types, codes and byte classifiers for the source text tokenizer.
package stt_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int OFFSET_WIDTH       = 16;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_P      = 8'h70;

    localparam logic [23:0] WORD_STR = 24'h737472;
    localparam logic [23:0] WORD_I32 = 24'h693332;

    localparam logic [15:0] LEN_ONE      = 16'd1;
    localparam logic [15:0] LEN_ELLIPSIS = 16'd3;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_COMMENT = 3'd1,
        M_INT     = 3'd2,
        M_STRING  = 3'd3,
        M_IDENT   = 3'd4,
        M_DOT1    = 3'd5,
        M_DOT2    = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        K_ILLEGAL  = 4'd0,
        K_LPAREN   = 4'd1,
        K_RPAREN   = 4'd2,
        K_LBRACE   = 4'd3,
        K_RBRACE   = 4'd4,
        K_COMMA    = 4'd5,
        K_ELLIPSIS = 4'd6,
        K_KW_F     = 4'd7,
        K_KW_P     = 4'd8,
        K_KW_STR   = 4'd9,
        K_KW_I32   = 4'd10,
        K_INT      = 4'd11,
        K_STRING   = 4'd12,
        K_IDENT    = 4'd13,
        K_EOF      = 4'd14
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind   kind;
        logic [15:0] off;
        logic [15:0] len;
    } t_tok;

    typedef struct packed {
        t_tok [2:0] tok;
        logic [1:0] cnt;
    } t_bundle;

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic f_is_word(input logic [7:0] c);
        return f_is_alpha(c) || f_is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic f_is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic t_mode f_fresh_mode(input logic [7:0] c);
        t_mode m;
        m = M_IDLE;
        if (c == CH_HASH) m = M_COMMENT;
        else if (c == CH_DOT) m = M_DOT1;
        else if (c == CH_QUOTE) m = M_STRING;
        else if (f_is_digit(c)) m = M_INT;
        else if (f_is_alpha(c) || (c == CH_UNDER)) m = M_IDENT;
        return m;
    endfunction

    function automatic logic f_fresh_emits(input logic [7:0] c);
        return !f_is_space(c) && (f_fresh_mode(c) == M_IDLE);
    endfunction

    function automatic t_tok_kind f_sym_kind(input logic [7:0] c);
        t_tok_kind k;
        case (c)
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_COMMA:  k = K_COMMA;
            default:   k = K_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

/* src/stt_scan.sv */
// Scanner state and per-byte token decision for the source text tokenizer.
module stt_scan
    import stt_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic        i_kind,
    input  logic [7:0]  i_byte,
    output t_bundle     o_bnd
);

    localparam int PW = POSITION_WIDTH;

    t_mode          r_mode, n_mode;
    logic [PW-1:0]  r_pos, n_pos;
    logic [PW-1:0]  r_begin, n_begin;
    logic [23:0]    r_prefix, n_prefix;
    logic [1:0]     r_wlen, n_wlen;

    logic           w_dig, w_word, w_dot, w_close;
    logic           w_flush, w_fresh;
    logic [PW-1:0]  w_pos_inc, w_begin_inc;
    t_tok           w_ft0, w_ft1, w_tail;
    logic           w_ft0v, w_ft1v, w_tailv;
    t_tok_kind      w_ident_kind;

    function automatic logic [15:0] f_clamp(input logic [PW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (|w[31:16]) ? 16'hFFFF : w[15:0];
    endfunction

    always_comb begin
        w_dig       = f_is_digit(i_byte);
        w_word      = f_is_word(i_byte);
        w_dot       = (i_byte == CH_DOT);
        w_close     = (i_byte == CH_QUOTE) || (i_byte == CH_LF);
        w_pos_inc   = (r_pos == '1) ? r_pos : r_pos + 1'b1;
        w_begin_inc = (r_begin == '1) ? r_begin : r_begin + 1'b1;
        case (r_mode)
            M_INT:   w_flush = i_kind || !w_dig;
            M_IDENT: w_flush = i_kind || !w_word;
            M_DOT1:  w_flush = i_kind || !w_dot;
            M_DOT2:  w_flush = i_kind || !w_dot;
            M_STRING: w_flush = i_kind;
            default: w_flush = 1'b0;
        endcase
        w_fresh = !i_kind && ((r_mode == M_IDLE) || w_flush);
        if (r_wlen == 2'd1 && r_prefix == {16'b0, CH_F}) w_ident_kind = K_KW_F;
        else if (r_wlen == 2'd1 && r_prefix == {16'b0, CH_P}) w_ident_kind = K_KW_P;
        else if (r_wlen == 2'd3 && r_prefix == WORD_STR) w_ident_kind = K_KW_STR;
        else if (r_wlen == 2'd3 && r_prefix == WORD_I32) w_ident_kind = K_KW_I32;
        else w_ident_kind = K_IDENT;
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_begin  = r_begin;
        n_prefix = r_prefix;
        n_wlen   = r_wlen;
        if (i_kind) begin
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_begin  = '0;
            n_prefix = '0;
            n_wlen   = '0;
        end else begin
            n_pos = w_pos_inc;
            case (r_mode)
                M_COMMENT: begin
                    if (i_byte == CH_LF) n_mode = M_IDLE;
                end
                M_STRING: begin
                    if (w_close) n_mode = M_IDLE;
                end
                M_IDENT: begin
                    if (w_word) begin
                        if (r_wlen != 2'd3) begin
                            n_prefix = {r_prefix[15:0], i_byte};
                            n_wlen   = r_wlen + 2'd1;
                        end else begin
                            n_prefix = '0;
                        end
                    end
                end
                M_DOT1: begin
                    if (w_dot) n_mode = M_DOT2;
                end
                M_DOT2: begin
                    if (w_dot) n_mode = M_IDLE;
                end
                default: ;
            endcase
            if (w_fresh) begin
                n_begin = r_pos;
                n_mode  = f_fresh_mode(i_byte);
                if (f_fresh_mode(i_byte) == M_IDENT) begin
                    n_prefix = {16'b0, i_byte};
                    n_wlen   = 2'd1;
                end
            end
        end
    end

    always_comb begin
        w_ft0.off = f_clamp(r_begin);
        w_ft0.len = f_clamp(r_pos - r_begin);
        w_ft0v    = w_flush;
        case (r_mode)
            M_INT:    w_ft0.kind = K_INT;
            M_STRING: w_ft0.kind = K_STRING;
            M_IDENT:  w_ft0.kind = w_ident_kind;
            M_DOT1, M_DOT2: begin
                w_ft0.kind = K_ILLEGAL;
                w_ft0.len  = LEN_ONE;
            end
            default: begin
                w_ft0.kind = K_ILLEGAL;
                w_ft0v     = 1'b0;
            end
        endcase
        w_ft1.kind = K_ILLEGAL;
        w_ft1.off  = f_clamp(w_begin_inc);
        w_ft1.len  = LEN_ONE;
        w_ft1v     = w_flush && (r_mode == M_DOT2);

        w_tail.kind = f_sym_kind(i_byte);
        w_tail.off  = f_clamp(r_pos);
        w_tail.len  = LEN_ONE;
        w_tailv     = 1'b0;
        if (i_kind) begin
            w_tail.kind = K_EOF;
            w_tailv     = 1'b1;
        end else if (w_fresh) begin
            w_tailv = f_fresh_emits(i_byte);
        end else if (r_mode == M_STRING && w_close) begin
            w_tail.kind = K_STRING;
            w_tail.off  = f_clamp(r_begin);
            w_tail.len  = f_clamp(w_pos_inc - r_begin);
            w_tailv     = 1'b1;
        end else if (r_mode == M_DOT2 && w_dot) begin
            w_tail.kind = K_ELLIPSIS;
            w_tail.off  = f_clamp(r_begin);
            w_tail.len  = LEN_ELLIPSIS;
            w_tailv     = 1'b1;
        end

        o_bnd.tok[0] = w_ft0v ? w_ft0 : w_tail;
        o_bnd.tok[1] = w_ft1v ? w_ft1 : w_tail;
        o_bnd.tok[2] = w_tail;
        o_bnd.cnt    = {1'b0, w_ft0v} + {1'b0, w_ft1v} + {1'b0, w_tailv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_begin  <= '0;
            r_prefix <= '0;
            r_wlen   <= '0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_begin  <= n_begin;
            r_prefix <= n_prefix;
            r_wlen   <= n_wlen;
        end
    end

endmodule

/* src/stt_serial.sv */
// Token bundle register and output register that send one token per transfer.
module stt_serial
    import stt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  t_bundle i_bnd,
    output logic    o_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_tok    o_out_tok,
    output logic    o_out_last
);

    t_tok [2:0] r_tok;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       r_ovalid;
    t_tok       r_otok;
    logic       r_olast;

    logic w_pending, w_out_free, w_move, w_final;

    always_comb begin
        w_pending  = (r_idx < r_cnt);
        w_out_free = !r_ovalid || i_out_ready;
        w_move     = w_pending && w_out_free;
        w_final    = (r_idx == r_cnt - 2'd1);
        o_ready    = !w_pending || (w_out_free && w_final);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_take) begin
                r_cnt <= i_bnd.cnt;
                r_idx <= '0;
            end else if (w_move) begin
                r_idx <= r_idx + 2'd1;
            end
            if (w_out_free) r_ovalid <= w_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) r_tok <= i_bnd.tok;
        if (w_move) begin
            r_otok  <= r_tok[r_idx];
            r_olast <= w_final;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_tok   = r_otok;
    assign o_out_last  = r_olast;

endmodule

/* src/source_text_tokenizer.sv */
// Top level of the source text tokenizer.
//
// channel  | direction | tdata                      | tuser          | tlast
// s_axis   | in        | [7:0] data_byte            | [0] kind       | -
// m_axis   | out       | [15:0] start_offset,       | [3:0]          | run_last
//          |           | [31:16] token_length       | token_kind     |
//
// One source byte is taken per cycle while m_axis is ready and no byte yields more
// than one token; a byte with more holds the input until its last token moves out.
// Tokens go from the bundle register to the output register, one token per transfer.
// The bundle register holds the next byte's tokens while the output register stalls.
// Synchronous active-low reset returns the scanner to the start of a stream.
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] start_offset, [31:16] token_length
    output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    output logic        m_axis_tlast
);

    t_bundle w_bnd;
    t_tok    w_otok;
    logic    w_take;

    assign w_take = s_axis_tvalid && s_axis_tready;

    stt_scan #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_kind  (s_axis_tuser[0]),
        .i_byte  (s_axis_tdata),
        .o_bnd   (w_bnd)
    );

    stt_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_bnd       (w_bnd),
        .o_ready     (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tok   (w_otok),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {w_otok.len, w_otok.off};
    assign m_axis_tuser = w_otok.kind;

endmodule

/* src/stt_chk.sv */
// Port-level checker for the source text tokenizer, bound to the top level.
module stt_chk
    import stt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_axis_tvalid) && !$past(m_axis_tready)
        |-> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output transfer changed");

    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == K_EOF)
        |-> m_axis_tlast && (m_axis_tdata[31:16] == LEN_ONE))
        else $error("eof token not last or wrong length");

    a_ellipsis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == K_ELLIPSIS)
        |-> m_axis_tlast && (m_axis_tdata[31:16] == LEN_ELLIPSIS))
        else $error("ellipsis token not last or wrong length");

endmodule

bind source_text_tokenizer stt_chk u_chk (.*);
